>>> hw/rtl/efu_pkg.sv
// efu_pkg: shared types and constants for the encoder frame unwrapper
// frame header codes, axis codes, unwrap thresholds and the unwrap result struct
// no dependencies
package efu_pkg;

   // frame header codes
   localparam logic [7:0] HDR_YAW   = 8'hB4;
   localparam logic [7:0] HDR_PITCH = 8'hB2;
   localparam logic [7:0] HDR_THIRD = 8'hB1;

   // unwrap thresholds
   localparam int JUMP_LIMIT  = 15000;
   localparam int TURN_SPAN   = 32767;
   localparam int HALF_WINDOW = 16384;

   typedef enum logic [1:0] {
      AXIS_NONE  = 2'd0,
      AXIS_YAW   = 2'd1,
      AXIS_PITCH = 2'd2,
      AXIS_THIRD = 2'd3
   } efu_axis_type;

   // one axis update: new raw position and accumulator before folding
   typedef struct packed {
      logic signed [15:0] last;
      logic signed [31:0] acc;
   } efu_unwrap_type;

endpackage

>>> hw/rtl/efu_unwrap.sv
// efu_unwrap: one multi-turn unwrap step for a single axis
// takes the stored raw position and accumulator, returns their next values
// depends on efu_pkg
module efu_unwrap
   import efu_pkg::*;
(
   input  logic signed [15:0] last,
   input  logic signed [15:0] pos,
   input  logic               ok,
   input  logic signed [31:0] acc,
   output efu_unwrap_type     nxt
);

   logic signed [15:0] raw;
   logic signed [16:0] delta;
   logic signed [16:0] step;

   always_comb begin
      // a bad frame repeats the last position, so the delta is zero
      raw   = ok ? pos : last;
      delta = 17'(raw) - 17'(last);
      if (delta > 17'sd15000) begin
         step = delta - 17'(TURN_SPAN);
      end else if (delta < -17'sd15000) begin
         step = delta + 17'(TURN_SPAN);
      end else begin
         step = delta;
      end
      nxt.last = raw;
      nxt.acc  = acc + 32'(step);
   end

endmodule

>>> hw/rtl/encoder_frame_unwrapper.sv
// encoder_frame_unwrapper: checks 4-byte encoder frames and keeps per-axis positions
// the result beat is registered: it is valid in the cycle after the frame beat is accepted
// throughput: one frame per cycle while no result beat is stalled; the whole update is a single registered pass
// reset (synchronous, active high) clears all positions, accumulators and the yaw center register
// depends on efu_pkg and efu_unwrap
module encoder_frame_unwrapper
   import efu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_wr_en,
   input  logic signed [15:0] csr_wr_data,
   // frame beats
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_header_byte,
   input  logic [7:0]         req_pos_high,
   input  logic [7:0]         req_pos_low,
   input  logic [7:0]         req_check_byte,
   // result beats
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_axis,
   output logic               rsp_check_ok,
   output logic signed [31:0] rsp_yaw_total,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [31:0] rsp_third_total
);

   // configuration register
   logic signed [15:0] center_ff;

   // axis state; raw and previous position are always equal between frames,
   // so one register per axis holds both
   logic signed [15:0] yaw_last_ff,   yaw_last_in;
   logic signed [31:0] yaw_acc_ff,    yaw_acc_in;
   logic               yaw_seen_ff,   yaw_seen_in;
   logic signed [15:0] pitch_ff,      pitch_in;
   logic signed [15:0] third_last_ff, third_last_in;
   logic signed [31:0] third_acc_ff,  third_acc_in;

   // result register
   logic               rsp_valid_ff,  rsp_valid_in;
   efu_axis_type       axis_ff,       axis_in;
   logic               check_ok_ff,   check_ok_in;

   logic               accept;
   logic               ok;
   logic signed [15:0] pos;
   efu_unwrap_type     yaw_nxt;
   efu_unwrap_type     third_nxt;
   logic signed [31:0] win_hi;
   logic signed [31:0] win_lo;

   // the result register frees up when its beat is taken, so a new frame can
   // enter in the same cycle
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // frame fields
   assign ok  = (req_header_byte + req_pos_high + req_pos_low) == req_check_byte;
   assign pos = {req_pos_high, req_pos_low};

   efu_unwrap u_yaw (
      .last (yaw_last_ff),
      .pos  (pos),
      .ok   (ok),
      .acc  (yaw_acc_ff),
      .nxt  (yaw_nxt)
   );

   efu_unwrap u_third (
      .last (third_last_ff),
      .pos  (pos),
      .ok   (ok),
      .acc  (third_acc_ff),
      .nxt  (third_nxt)
   );

   // yaw folding window bounds
   assign win_hi = 32'(center_ff) + 32'(HALF_WINDOW);
   assign win_lo = 32'(center_ff) - 32'(HALF_WINDOW);

   always_comb begin
      yaw_last_in   = yaw_last_ff;
      yaw_acc_in    = yaw_acc_ff;
      yaw_seen_in   = yaw_seen_ff;
      pitch_in      = pitch_ff;
      third_last_in = third_last_ff;
      third_acc_in  = third_acc_ff;
      axis_in       = axis_ff;
      check_ok_in   = check_ok_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;

      if (accept) begin
         rsp_valid_in = 1'b1;
         check_ok_in  = ok;
         unique case (req_header_byte)
            HDR_YAW: begin
               axis_in     = AXIS_YAW;
               yaw_last_in = yaw_nxt.last;
               // fold back into center +/- half window
               if (yaw_nxt.acc >= win_hi) begin
                  yaw_acc_in = yaw_nxt.acc - 32'(TURN_SPAN);
               end else if (yaw_nxt.acc <= win_lo) begin
                  yaw_acc_in = yaw_nxt.acc + 32'(TURN_SPAN);
               end else begin
                  yaw_acc_in = yaw_nxt.acc;
               end
               // first yaw frame while the stored position is still zero
               // loads the accumulator directly
               if (yaw_last_ff == 16'sd0 && !yaw_seen_ff) begin
                  yaw_acc_in = 32'(yaw_nxt.last);
               end
               yaw_seen_in = 1'b1;
            end
            HDR_PITCH: begin
               axis_in = AXIS_PITCH;
               if (ok) begin
                  pitch_in = pos;
               end
            end
            HDR_THIRD: begin
               axis_in       = AXIS_THIRD;
               third_last_in = third_nxt.last;
               third_acc_in  = third_nxt.acc;
            end
            default: begin
               // unknown header: state holds
               axis_in = AXIS_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff     <= '0;
         yaw_last_ff   <= '0;
         yaw_acc_ff    <= '0;
         yaw_seen_ff   <= 1'b0;
         pitch_ff      <= '0;
         third_last_ff <= '0;
         third_acc_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         axis_ff       <= AXIS_NONE;
         check_ok_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            center_ff <= csr_wr_data;
         end
         yaw_last_ff   <= yaw_last_in;
         yaw_acc_ff    <= yaw_acc_in;
         yaw_seen_ff   <= yaw_seen_in;
         pitch_ff      <= pitch_in;
         third_last_ff <= third_last_in;
         third_acc_ff  <= third_acc_in;
         rsp_valid_ff  <= rsp_valid_in;
         axis_ff       <= axis_in;
         check_ok_ff   <= check_ok_in;
      end
   end

   // positions come straight from the state: it only moves when a frame is
   // accepted, which cannot happen while a result beat is stalled
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_axis        = axis_ff;
   assign rsp_check_ok    = check_ok_ff;
   assign rsp_yaw_total   = yaw_acc_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_third_total = third_acc_ff;

endmodule

>>> hw/rtl/efu_checker.sv
// efu_checker: port-level assertions for encoder_frame_unwrapper, bound to the top
// depends on efu_pkg
module efu_checker
   import efu_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_header_byte,
   input logic [7:0]         req_pos_high,
   input logic [7:0]         req_pos_low,
   input logic [7:0]         req_check_byte,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_check_ok,
   input logic signed [31:0] rsp_yaw_total,
   input logic signed [15:0] rsp_pitch_angle,
   input logic signed [31:0] rsp_third_total
);

   logic       req_acc;
   logic       sum_ok;

   assign req_acc = req_valid & ~req_stall;
   assign sum_ok  = (req_header_byte + req_pos_high + req_pos_low) == req_check_byte;

   // an accepted frame always yields a result beat next cycle
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> rsp_valid)
      else $error("accepted frame produced no result beat");

   // frames are held off only while a result beat is stuck
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with free result register");

   // result reports the checksum of the frame just taken
   a_check: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (rsp_check_ok == $past(sum_ok)))
      else $error("check_ok does not match frame sum");

   // a good pitch frame shows up as the pitch angle
   a_pitch: assert property (@(posedge clock) disable iff (reset)
      (req_acc && sum_ok && req_header_byte == HDR_PITCH) |=>
         (rsp_pitch_angle == $past({req_pos_high, req_pos_low})))
      else $error("pitch angle not taken from good pitch frame");

   // stalled result beat holds its accumulators
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         ($stable(rsp_yaw_total) && $stable(rsp_third_total)))
      else $error("stalled result beat changed");

endmodule

bind encoder_frame_unwrapper efu_checker u_efu_checker (.*);
